@@ design/fcct_pkg.sv @@
// Shared types and constants of the FAT16 cluster chain table.
// Used by the table engine and the top level; depends on nothing.
`timescale 1ns / 1ps

package fcct_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES      = 4096;
    localparam int ENTRIES_PER_SECTOR = 256;
    localparam int ADDR_W             = $clog2(TABLE_ENTRIES);
    localparam int SECTOR_W           = $clog2(ENTRIES_PER_SECTOR);
    localparam int ENTRY_W            = 16;
    localparam int LIMIT_W            = 13;
    localparam int SCAN_W             = ADDR_W + 1;
    localparam int TABLE_SECTORS      = TABLE_ENTRIES / ENTRIES_PER_SECTOR;
    localparam int SECTOR_CNT_W       = LIMIT_W + 1 - SECTOR_W;

    // Entry values with a fixed meaning
    localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 16'hFFFF;
    localparam logic [ENTRY_W-1:0] FREE_ENTRY   = 16'h0000;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_NEXT = 2'd0,
        KIND_FREE = 2'd1,
        KIND_LINK = 2'd2,
        KIND_LOAD = 2'd3
    } fcct_kind_t;

    // Engine sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_LINK_EOC,
        ST_DONE
    } fcct_state_t;

    // Result handed from the engine to the output register
    typedef struct packed {
        logic               valid;
        logic [ENTRY_W-1:0] value;
        logic               found;
    } fcct_resp_t;

endpackage

@@ design/fcct_ram.sv @@
// Generic single-port RAM with registered, read-first output.
// Stands alone; depends on nothing.
`timescale 1ns / 1ps

module fcct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: write and registered read at the same address
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ design/fcct_engine.sv @@
// Sequencer and scan unit of the cluster chain table: owns the table RAM.
// Depends on fcct_pkg and fcct_ram.
`timescale 1ns / 1ps

module fcct_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fcct_pkg::fcct_kind_t        in_kind,
    input  logic [fcct_pkg::ADDR_W-1:0] in_cluster_a,
    input  logic [fcct_pkg::ADDR_W-1:0] in_cluster_b,
    input  logic [fcct_pkg::ENTRY_W-1:0] in_entry_value,
    input  logic [fcct_pkg::SCAN_W-1:0] scan_end,
    input  logic                        out_free,
    output fcct_pkg::fcct_resp_t        resp
);
    import fcct_pkg::*;

    fcct_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]   b_reg, b_next;
    logic [SCAN_W-1:0]   scan_addr_reg, scan_addr_next;
    logic [ENTRY_W-1:0]  res_value_reg, res_value_next;
    logic                res_found_reg, res_found_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                accept;
    logic [SCAN_W-1:0]   scan_inc;
    logic                scan_hit;
    logic                scan_last;

    fcct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Shared scan unit: increment and the two compares
    assign accept    = in_valid && in_ready;
    assign scan_inc  = scan_addr_reg + SCAN_W'(1);
    assign scan_hit  = (ram_rdata == FREE_ENTRY);
    assign scan_last = (scan_inc == scan_end);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_kind)
                        KIND_NEXT: state_next = ST_LOOKUP;
                        KIND_FREE: state_next = ST_SCAN;
                        KIND_LINK: state_next = ST_LINK_EOC;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOOKUP:   state_next = ST_DONE;
            ST_SCAN: begin
                if (scan_hit || scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_LINK_EOC: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake, RAM port and result
    always_comb begin
        in_ready   = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = in_cluster_a;
        ram_wdata  = in_entry_value;
        resp.valid = 1'b0;
        resp.value = res_value_reg;
        resp.found = res_found_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                case (in_kind)
                    KIND_NEXT: ram_addr = in_cluster_a;
                    KIND_FREE: ram_addr = '0;
                    KIND_LINK: begin
                        // A link from cluster 0 only marks the end of chain
                        ram_we    = in_valid && (in_cluster_a != '0);
                        ram_wdata = ENTRY_W'(in_cluster_b);
                    end
                    default:   ram_we = in_valid;
                endcase
            end
            ST_SCAN: begin
                ram_addr = scan_inc[ADDR_W-1:0];
            end
            ST_LINK_EOC: begin
                ram_we    = 1'b1;
                ram_addr  = b_reg;
                ram_wdata = END_OF_CHAIN;
            end
            ST_DONE: begin
                resp.valid = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Datapath registers of the sequencer
    always_comb begin
        b_next         = b_reg;
        scan_addr_next = scan_addr_reg;
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    b_next         = in_cluster_b;
                    scan_addr_next = '0;
                    res_value_next = '0;
                    res_found_next = 1'b1;
                end
            end
            ST_LOOKUP: begin
                res_value_next = ram_rdata;
            end
            ST_SCAN: begin
                scan_addr_next = scan_inc;
                if (scan_hit) begin
                    res_value_next = ENTRY_W'(scan_addr_reg);
                end else if (scan_last) begin
                    res_found_next = 1'b0;
                end
            end
            default: begin
                b_next = b_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg         <= b_next;
        scan_addr_reg <= scan_addr_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
    end

endmodule

@@ design/fat16_cluster_chain_table.sv @@
// Top level of the FAT16 cluster chain table: stream ports, scan limit
// register and output register. Depends on fcct_pkg and fcct_engine.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one request per transfer: kind in s_tuser
// (0 next, 1 find free, 2 link, 3 load) and the clusters and entry value in
// s_tdata. Every request gives exactly one result on the master stream:
// the entry or free cluster in m_tdata and the found flag in m_tuser.
// The cfg channel writes the scan limit; it is always ready and should only
// be written while no request is in flight.
// A load is written when it is accepted; a next lookup reads its entry in
// the lookup state, a link writes the end-of-chain mark in its own state,
// and a free scan reads entries in the scan state up to a hit or the limit.
// One request is worked on at a time; the table RAM has a single port,
// which the free scan walks one entry per cycle.
// The next request is taken while a result still waits in the output
// register; the engine holds its own result when the receiver stalls.
// Reset returns the sequencer to idle and the scan limit to 4096 entries;
// the table contents are undefined until loaded.
module fat16_cluster_chain_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cluster_a[11:0], cluster_b[23:12], entry_value[39:24]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // result_value[15:0]
    output logic        m_tuser,   // found[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data   // scan_limit[12:0]
);
    import fcct_pkg::*;

    logic [SCAN_W-1:0]       scan_end_reg, scan_end_next;
    logic [LIMIT_W:0]        limit_round;
    logic [SECTOR_CNT_W-1:0] sectors;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [ENTRY_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    logic                    out_free;
    fcct_resp_t              resp;

    fcct_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_kind        (fcct_kind_t'(s_tuser)),
        .in_cluster_a   (s_tdata[11:0]),
        .in_cluster_b   (s_tdata[23:12]),
        .in_entry_value (s_tdata[39:24]),
        .scan_end       (scan_end_reg),
        .out_free       (out_free),
        .resp           (resp)
    );

    // Scan limit: rounded up to whole sectors, at least one, at most the table
    assign cfg_ready   = 1'b1;
    assign limit_round = {1'b0, cfg_data} + (LIMIT_W + 1)'(ENTRIES_PER_SECTOR - 1);
    assign sectors     = limit_round[LIMIT_W:SECTOR_W];

    always_comb begin
        scan_end_next = scan_end_reg;
        if (cfg_valid && cfg_ready) begin
            if (sectors == '0) begin
                scan_end_next = SCAN_W'(ENTRIES_PER_SECTOR);
            end else if (sectors > SECTOR_CNT_W'(TABLE_SECTORS)) begin
                scan_end_next = SCAN_W'(TABLE_ENTRIES);
            end else begin
                scan_end_next = SCAN_W'({sectors, {SECTOR_W{1'b0}}});
            end
        end
    end

    // Output register parts the engine from the receiver
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_free) begin
            m_tvalid_next = resp.valid;
            m_tdata_next  = resp.value;
            m_tuser_next  = resp.found;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_end_reg <= SCAN_W'(TABLE_ENTRIES);
            m_tvalid_reg <= 1'b0;
        end else begin
            scan_end_reg <= scan_end_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the FAT16 cluster chain table, with a mirror of
// the allocation table that predicts every result. Depends on fcct_pkg and
// fat16_cluster_chain_table.
`timescale 1ns / 1ps

module tb;

    import fcct_pkg::*;

    // One request as the slave stream carries it
    typedef struct packed {
        fcct_kind_t          kind;
        logic [ADDR_W-1:0]   clu_a;
        logic [ADDR_W-1:0]   clu_b;
        logic [ENTRY_W-1:0]  value;
    } fat_req_t;

    // One result as the master stream carries it
    typedef struct packed {
        logic [ENTRY_W-1:0] value;
        logic               found;
    } fat_resp_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata   = '0;   // cluster_a[11:0], cluster_b[23:12], entry_value[39:24]
    logic [1:0]         s_tuser   = '0;   // kind[1:0]
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [15:0]        m_tdata;          // result_value[15:0]
    logic               m_tuser;          // found[0]
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data  = '0;   // scan_limit[12:0]

    // Mirror of the table, which entries were ever written, and the scan limit
    logic [ENTRY_W-1:0] fat_mirror [TABLE_ENTRIES];
    bit                 written [TABLE_ENTRIES];
    int                 written_list [$];
    logic [LIMIT_W-1:0] limit_mirror;
    fat_resp_t          last_answer;

    // Requests waiting for the driver and answers waiting for the monitor
    fat_req_t           request_q [$];
    fat_resp_t          answer_q [$];
    fat_req_t           tx_req;
    fat_resp_t          want;
    bit                 tx_busy    = 1'b0;
    int                 gap_left   = 0;
    int                 stall_left = 0;
    bit                 send_burst = 1'b0;
    bit                 recv_burst = 1'b0;

    int                 issued_n   = 0;
    int                 accepted_n = 0;
    int                 results_n  = 0;
    int                 err_n      = 0;
    int                 kind_n [4] = '{0, 0, 0, 0};
    int                 nofree_n   = 0;
    int                 phase_n    = 0;
    int                 chain_tail = 0;

    fat16_cluster_chain_table u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Guard against a hung run
    initial begin
        #40_000_000;
        $display("Timed out: %0d requests sent, %0d results seen", issued_n, results_n);
        $display("[fat16_cluster_chain_table] ERROR");
        $finish;
    end

    // Number of entries a free search walks at most: whole sectors, at least
    // one, never past the end of the table.
    function automatic int scan_span();
        int sectors;
        int span;
        sectors = (int'(limit_mirror) + ENTRIES_PER_SECTOR - 1) / ENTRIES_PER_SECTOR;
        if (sectors == 0) begin
            sectors = 1;
        end
        span = sectors * ENTRIES_PER_SECTOR;
        return (span > TABLE_ENTRIES) ? TABLE_ENTRIES : span;
    endfunction

    function automatic void put_entry(int idx, logic [ENTRY_W-1:0] v);
        fat_mirror[idx] = v;
        if (!written[idx]) begin
            written[idx] = 1'b1;
            written_list.push_back(idx);
        end
    endfunction

    // Applies one request to the mirror and returns the result it gives.
    function automatic fat_resp_t apply_request(fat_req_t r);
        fat_resp_t res;
        int        span;
        int        i;
        res.value = FREE_ENTRY;
        res.found = 1'b1;
        case (r.kind)
            KIND_NEXT: res.value = fat_mirror[r.clu_a];
            KIND_FREE: begin
                span = scan_span();
                res.found = 1'b0;
                for (i = 0; i < span && !res.found; i++) begin
                    if (fat_mirror[i] == FREE_ENTRY) begin
                        res.value = ENTRY_W'(i);
                        res.found = 1'b1;
                    end
                end
            end
            KIND_LINK: begin
                // The end-of-chain mark goes in last, so it wins on a self link
                if (r.clu_a != '0) begin
                    put_entry(int'(r.clu_a), ENTRY_W'(r.clu_b));
                end
                put_entry(int'(r.clu_b), END_OF_CHAIN);
            end
            default: put_entry(int'(r.clu_a), r.value);
        endcase
        kind_n[int'(r.kind)]++;
        if (!res.found) begin
            nofree_n++;
        end
        return res;
    endfunction

    // First entry a free search would read before it was ever written, or -1
    // when the search would stop on a free entry or at its span first.
    function automatic int scan_hole();
        int span;
        int i;
        int hole;
        span = scan_span();
        hole = -1;
        i = 0;
        while (i < span && hole < 0 && !(written[i] && fat_mirror[i] == FREE_ENTRY)) begin
            if (!written[i]) begin
                hole = i;
            end
            i++;
        end
        return hole;
    endfunction

    function automatic logic [ENTRY_W-1:0] used_entry();
        return ENTRY_W'($urandom_range(1, 65535));
    endfunction

    function automatic logic [ENTRY_W-1:0] any_entry();
        case ($urandom_range(0, 7))
            0: return FREE_ENTRY;
            1: return END_OF_CHAIN;
            default: return ENTRY_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] phase_limit(int p);
        case (p)
            0: return 13'd0;
            1: return 13'd8191;
            2: return 13'd1;
            3: return 13'd300;
            4: return 13'd4096;
            5: return 13'd256;
            6: return 13'd4095;
            7: return 13'd257;
            default: return 13'd512;
        endcase
    endfunction

    function automatic void note_error(string what);
        err_n++;
        if (err_n <= 10) begin
            $display("Mismatch at %0t: %s", $realtime, what);
        end
    endfunction

    // Queues one request and waits until the block has taken it, so that the
    // mirror is up to date when the next request is chosen.
    task automatic send(fcct_kind_t k, int a, int b, logic [ENTRY_W-1:0] v);
        fat_req_t r;
        r.kind  = k;
        r.clu_a = ADDR_W'(a);
        r.clu_b = ADDR_W'(b);
        r.value = v;
        request_q.push_back(r);
        issued_n++;
        wait (accepted_n == issued_n);
    endtask

    task automatic drain();
        wait (results_n == issued_n);
    endtask

    // Free search, preceded by loads that fill any entry it would otherwise
    // read before it was ever written.
    task automatic find_free();
        int hole;
        hole = scan_hole();
        while (hole >= 0) begin
            send(KIND_LOAD, hole, $urandom_range(0, 4095),
                 ($urandom_range(0, 2) == 0) ? FREE_ENTRY : used_entry());
            hole = scan_hole();
        end
        send(KIND_FREE, $urandom_range(0, 4095), $urandom_range(0, 4095), ENTRY_W'($urandom));
    endtask

    // Allocates one cluster the way a file system grows a file: find a free
    // entry, then link it behind the current tail of the chain.
    task automatic allocate(output bit got);
        int fresh;
        find_free();
        got = last_answer.found;
        if (got) begin
            fresh = int'(last_answer.value);
            send(KIND_LINK, chain_tail, fresh, ENTRY_W'($urandom));
            chain_tail = fresh;
        end else begin
            chain_tail = 0;
        end
    endtask

    task automatic random_op();
        int pick;
        bit got;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            allocate(got);
            if ($urandom_range(0, 9) == 0) begin
                chain_tail = 0;
            end
        end else if (pick < 55) begin
            send(KIND_NEXT, written_list[$urandom_range(0, written_list.size() - 1)],
                 $urandom_range(0, 4095), ENTRY_W'($urandom));
        end else if (pick < 70) begin
            send(KIND_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095), any_entry());
        end else if (pick < 85) begin
            send(KIND_LINK, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 4095),
                 $urandom_range(0, 4095), ENTRY_W'($urandom));
        end else begin
            find_free();
        end
    endtask

    // The scan limit is only written once every result is back.
    task automatic set_limit(logic [LIMIT_W-1:0] v);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        limit_mirror = v;
        phase_n++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Request driver: waits its drawn gap, then presents the next request and
    // holds it until it is taken.
    always @(negedge aclk) begin
        if (aresetn && !tx_busy) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
                tx_req = request_q.pop_front();
                tx_busy = 1'b1;
                s_tvalid <= 1'b1;
                s_tuser  <= tx_req.kind;
                s_tdata  <= {tx_req.value, tx_req.clu_b, tx_req.clu_a};
                gap_left = send_burst ? 0 : $urandom_range(0, 8);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // A request taken by the block updates the mirror and books its answer.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            last_answer = apply_request(tx_req);
            answer_q.push_back(last_answer);
            tx_busy = 1'b0;
            accepted_n++;
        end
    end

    // Result receiver: stalls for its drawn number of cycles after each result.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result monitor: each result against the oldest answer still due.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_n++;
            stall_left = recv_burst ? 0 : $urandom_range(0, 8);
            if (answer_q.size() == 0) begin
                note_error($sformatf("result value %h found %b with no request due",
                                     m_tdata, m_tuser));
            end else begin
                want = answer_q.pop_front();
                if (m_tdata !== want.value) begin
                    note_error($sformatf("result_value expected %h, got %h",
                                         want.value, m_tdata));
                end
                if (m_tuser !== want.found) begin
                    note_error($sformatf("found expected %b, got %b", want.found, m_tuser));
                end
            end
        end
    end

    initial begin
        int  p;
        int  k;
        bit  got;
        limit_mirror = LIMIT_W'(TABLE_ENTRIES);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests: free entry at cluster 0, extreme clusters and
        // values, a link from cluster 0, a self link and a plain link.
        send(KIND_LOAD, 0, 0, FREE_ENTRY);
        send(KIND_FREE, 4095, 4095, 16'hFFFF);
        send(KIND_NEXT, 0, 0, 16'h0000);
        send(KIND_LOAD, 4095, 4095, END_OF_CHAIN);
        send(KIND_NEXT, 4095, 0, 16'h0000);
        send(KIND_LOAD, 1, 0, FREE_ENTRY);
        send(KIND_LOAD, 0, 4095, 16'h8001);
        send(KIND_FREE, 0, 0, 16'h0000);
        send(KIND_LINK, 0, 1, 16'h0000);
        send(KIND_NEXT, 1, 0, 16'h0000);
        send(KIND_LINK, 5, 5, 16'h0000);
        send(KIND_NEXT, 5, 0, 16'h0000);
        send(KIND_LINK, 4095, 2, 16'hFFFF);
        send(KIND_NEXT, 4095, 0, 16'h0000);
        send(KIND_NEXT, 2, 0, 16'h0000);
        send(KIND_LOAD, 3, 0, 16'h5A5A);
        send(KIND_LOAD, 4094, 0, 16'hA5A5);
        send(KIND_LINK, 3, 4094, 16'h0000);
        send(KIND_NEXT, 3, 0, 16'h0000);
        send(KIND_NEXT, 4094, 0, 16'h0000);
        send(KIND_LOAD, 4, 0, FREE_ENTRY);
        send(KIND_FREE, 0, 0, 16'h0000);

        // Software fills the first sector, leaving a few entries free
        for (k = 0; k < ENTRIES_PER_SECTOR; k++) begin
            send(KIND_LOAD, k, $urandom_range(0, 4095),
                 ($urandom_range(0, 15) == 0) ? FREE_ENTRY : used_entry());
        end

        // One phase per scan limit; the first allocates until nothing is free
        for (p = 0; p < 9; p++) begin
            set_limit(phase_limit(p));
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            if (p == 0) begin
                chain_tail = 0;
                got = 1'b1;
                while (got) begin
                    allocate(got);
                end
            end
            repeat (18) random_op();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (answer_q.size() != 0) begin
            note_error($sformatf("%0d results never arrived", answer_q.size()));
        end
        $display("Ran %0d next, %0d find-free (%0d with no free entry), %0d link, %0d load",
                 kind_n[0], kind_n[1], nofree_n, kind_n[2], kind_n[3]);
        $display("Scan limit changed %0d times; %0d mismatches", phase_n, err_n);
        if (err_n == 0) begin
            $display("[fat16_cluster_chain_table] OK");
        end else begin
            $display("[fat16_cluster_chain_table] ERROR");
        end
        $finish;
    end

endmodule
